@@ rtl/palette_fade_engine_macros.svh @@
// Assertion macros shared by the checker files of the palette fade engine.
`ifndef PALETTE_FADE_ENGINE_MACROS_SVH
`define PALETTE_FADE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and constants of the palette fade engine: word formats, commands,
// controller states and the control/status groups between its modules.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam logic [1:0] CMD_SET_COLOR  = 2'd0;
	localparam logic [1:0] CMD_SET_TARGET = 2'd1;
	localparam logic [1:0] CMD_FADE_STEP  = 2'd2;

	localparam logic [7:0] CHROMA_MID = 8'd128;
	// chroma terms are formed on a +64-biased value, so add back the rest
	localparam logic [7:0] CHROMA_OFS = CHROMA_MID - 8'd64;

	// restoring divider: one quotient bit per cycle for an 8-bit magnitude
	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = 3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] entry_index;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] steps_left;
	} pfe_req_t;

	typedef struct packed {
		logic [7:0] entry_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] luma;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
	} pfe_rsp_t;

	// one palette entry: index 2 red, 1 green, 0 blue; diff is signed 9 bits
	typedef struct packed {
		logic [2:0][8:0] diff;
		logic [2:0][7:0] color;
	} pfe_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIVIDE,
		ST_WRITE
	} pfe_state_t;

	typedef struct packed {
		logic capture;
		logic mem_rd;
		logic div_load;
		logic div_step;
		logic commit;
	} pfe_ctl_t;

	typedef struct packed {
		logic fade;
		logic in_range;
	} pfe_stat_t;

endpackage

@@ rtl/palette_fade_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_engine
// Color palette with a per-entry fade engine and luma/chroma result packing.
// ----------------------------------------------------------------------------
// Use: drive a word on req and raise start; it is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// Each word gives one result word on result, marked by done for exactly one
// cycle; the receiver cannot stall it, so it must take the word then.
// A fade step on a stored entry goes through read, load, divide and write: the
// three channel dividers are restoring units giving one quotient bit per cycle.
// Every other word goes through read, load and write only.
// A new word may be started in the cycle in which done is high; no word is
// taken before the last one is done. The palette is a single-port memory read
// once and written at most once per word.
// Reset clears the sequencer, the result strobe and a valid bit per palette
// entry; an entry never written reads as zero color and zero difference, so
// no clearing pass is needed and the block is ready right after reset.
// Entries at or above ENTRIES are not stored and report a black color.
// ----------------------------------------------------------------------------
module palette_fade_engine
	import pfe_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pfe_req_t req,
	output pfe_rsp_t result,
	output logic     done
);

	pfe_ctl_t  ctl;
	pfe_stat_t stat;

	pfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	pfe_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

endmodule

@@ rtl/pfe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_div
// Restoring divider for 8-bit unsigned operands, one quotient bit per step.
// ----------------------------------------------------------------------------
module pfe_div
	import pfe_pkg::*;
(
	input  logic       clk,
	input  logic       load,
	input  logic       step,
	input  logic [7:0] dividend,
	input  logic [7:0] divisor,
	output logic [7:0] quotient
);

	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic [8:0] shifted;
	logic [8:0] trial;
	logic       fits;

	assign shifted = {rem_q, quo_q[7]};
	assign trial   = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= 8'd0;
			quo_q <= dividend;
		end else if (step) begin
			// remainder stays below divisor, so it fits 8 bits
			rem_q <= fits ? trial[7:0] : shifted[7:0];
			quo_q <= {quo_q[6:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

@@ rtl/pfe_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_datapath
// Palette memory with per-entry valid bits, three fade dividers, entry
// update and luma/chroma packing of the result word.
// ----------------------------------------------------------------------------
module pfe_datapath
	import pfe_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pfe_req_t  req,
	input  pfe_ctl_t  ctl,
	output pfe_stat_t stat,
	output pfe_rsp_t  result,
	output logic      done
);

	localparam int DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
	localparam int AW    = $clog2(DEPTH);

	pfe_entry_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	pfe_req_t   req_q;
	pfe_entry_t rd_data_q;
	logic       rd_vld_q;
	pfe_entry_t cur;
	pfe_entry_t nxt;
	pfe_rsp_t   rsp_d;
	pfe_rsp_t   rsp_q;
	logic       done_q;

	logic [AW-1:0] addr;
	logic          in_range;
	logic [7:0]    steps_eff;
	logic          mem_we;

	logic [2:0]      neg;
	logic [2:0][7:0] mag;
	logic [2:0][7:0] quo;
	logic [2:0][8:0] share;
	logic [2:0][8:0] tgt_diff;
	logic [2:0][7:0] tgt;
	logic [2:0][7:0] shown;

	logic [9:0]  luma_sum;
	logic [9:0]  u_sum;
	logic [10:0] v_sum;

	assign addr      = req_q.entry_index[AW-1:0];
	assign in_range  = (ENTRIES >= 256) ? 1'b1 : (32'(req_q.entry_index) < ENTRIES);
	assign steps_eff = (req_q.steps_left == 8'd0) ? 8'd1 : req_q.steps_left;
	assign tgt       = {req_q.red_in, req_q.green_in, req_q.blue_in};

	assign stat.fade     = req_q.cmd == CMD_FADE_STEP;
	assign stat.in_range = in_range;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= req;
		end
	end

	// never-written entries read as zero color and zero difference
	assign cur = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.mem_rd) begin
			rd_data_q <= mem[addr];
		end
		if (mem_we) begin
			mem[addr] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.mem_rd) begin
				rd_vld_q <= valid_q[addr];
			end
			if (mem_we) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	assign mem_we = ctl.commit && in_range;

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic [8:0] mag9;

		assign neg[k] = cur.diff[k][8];
		// difference stays within -255..255, so the magnitude fits 8 bits
		assign mag9   = neg[k] ? (9'd0 - cur.diff[k]) : cur.diff[k];
		assign mag[k] = mag9[7:0];

		pfe_div u_div (
			.clk      (clk),
			.load     (ctl.div_load),
			.step     (ctl.div_step),
			.dividend (mag[k]),
			.divisor  (steps_eff),
			.quotient (quo[k])
		);

		assign share[k]    = neg[k] ? (9'd0 - {1'b0, quo[k]}) : {1'b0, quo[k]};
		assign tgt_diff[k] = {1'b0, tgt[k]} - {1'b0, cur.color[k]};
	end

	always_comb begin
		nxt = cur;
		case (req_q.cmd)
			CMD_SET_COLOR: begin
				nxt.color = tgt;
			end
			CMD_SET_TARGET: begin
				nxt.diff = tgt_diff;
			end
			CMD_FADE_STEP: begin
				for (int k = 0; k < 3; k++) begin
					nxt.diff[k]  = cur.diff[k] - share[k];
					nxt.color[k] = cur.color[k] + share[k][7:0];
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign shown = in_range ? nxt.color : '0;

	always_comb begin
		luma_sum = 10'(shown[2]) + 10'(shown[1]) + 10'(shown[0]);
		u_sum    = 10'(shown[2]) + 10'd256 - 10'(shown[0]);
		v_sum    = {2'b00, shown[1], 1'b0} + 11'd512 - 11'(shown[2]) - 11'(shown[0]);

		rsp_d.entry_out = req_q.entry_index;
		rsp_d.red_out   = shown[2];
		rsp_d.green_out = shown[1];
		rsp_d.blue_out  = shown[0];
		rsp_d.luma      = luma_sum[9:2];
		rsp_d.chroma_u  = u_sum[9:2] + CHROMA_OFS;
		rsp_d.chroma_v  = v_sum[10:3] + CHROMA_OFS;
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.commit;
		end
	end

	assign result = rsp_q;
	assign done   = done_q;

endmodule

@@ rtl/pfe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: capture, palette read, load, divide iterations for a fade step on
// an in-range entry, then write-back and result.
// ----------------------------------------------------------------------------
module pfe_ctrl
	import pfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  pfe_stat_t stat,
	output pfe_ctl_t  ctl,
	output logic      busy
);

	pfe_state_t state_q;
	pfe_state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				ctl.mem_rd = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				// read word is registered now; only a fade step on an in-range entry needs the divider
				cnt_d = '0;
				if (stat.fade && stat.in_range) begin
					ctl.div_load = 1'b1;
					state_d      = ST_DIVIDE;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DIVIDE: begin
				ctl.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ctl.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/pfe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the palette fade engine's handshake and result word.
// ----------------------------------------------------------------------------
`include "palette_fade_engine_macros.svh"

module pfe_checker
	import pfe_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input pfe_rsp_t result,
	input logic     done
);

	`PFE_ASSERT_NOW(a_done_when_free, done, !busy, "result strobe while busy")
	`PFE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`PFE_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`PFE_ASSERT_NEXT(a_no_early_done, start && !busy, !done, "result in the cycle after accept")
	`PFE_ASSERT_NOW(a_chroma_range, done,
		result.luma <= 8'd191 && result.chroma_u >= 8'd64 && result.chroma_u <= 8'd191
		&& result.chroma_v >= 8'd64 && result.chroma_v <= 8'd191,
		"luma or chroma outside its range")

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.done   (done)
);
